FILE: src/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Each macro expands to one labeled concurrent assertion on the rising clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: src/bnk_pkg.sv
// Shared types and constants of the banker's safety and request engine.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package bnk_pkg;

  localparam int PROCS_DEF     = 8;
  localparam int RESOURCES_DEF = 4;
  localparam int AMT_W         = 8;
  localparam int WIDE_W        = 12;
  localparam int SUM_W         = WIDE_W + 1;
  localparam int MASK_W        = 8;
  localparam logic [WIDE_W-1:0] WIDE_MAX = '1;

  typedef enum logic [2:0] {
    MODE_ALLOC = 3'd0,
    MODE_NEED  = 3'd1,
    MODE_AVAIL = 3'd2,
    MODE_REQ   = 3'd3,
    MODE_CHECK = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_ACK    = 3'd0,
    ST_SEQ    = 3'd1,
    ST_SAFE   = 3'd2,
    ST_UNSAFE = 3'd3,
    ST_WAIT   = 3'd4,
    ST_EXCEED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RD_INPUT = 2'd0,
    RD_ZERO  = 2'd1,
    RD_NEXT  = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    ld_alloc;
    logic    ld_need;
    logic    ld_avail;
    logic    ld_req;
    logic    cap;
    logic    init;
    logic    grant;
    logic    take;
    logic    step;
    logic    commit;
    logic    clr_req;
    rd_sel_t rd_sel;
    logic    emit;
    status_t code;
    logic    last;
  } cmd_t;

  typedef struct packed {
    logic proc_ok;
    logic exceed;
    logic over_avail;
    logic can_take;
    logic at_end;
    logic all_done;
    logic granted;
  } sts_t;

endpackage

FILE: src/bnk_datapath.sv
// Datapath: allocation and need row memories, available, request buffer,
// work vector, finish flags, scan pointer and the result registers.
// Depends on bnk_pkg; driven by bnk_controller through cmd_t.
`timescale 1ns / 1ps

module bnk_datapath #(
  parameter int PROCS     = bnk_pkg::PROCS_DEF,
  parameter int RESOURCES = bnk_pkg::RESOURCES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  bnk_pkg::cmd_t cmd,
  input  logic [2:0]    process,
  input  logic [1:0]    resource,
  input  logic [7:0]    amount,
  input  logic [7:0]    finished_mask,
  output bnk_pkg::sts_t sts,
  output logic          result_valid,
  output logic [2:0]    status,
  output logic [2:0]    process_id,
  output logic          last
);
  import bnk_pkg::*;

  localparam int PW     = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int AROW_W = RESOURCES * WIDE_W;
  localparam int NROW_W = RESOURCES * AMT_W;

  // One row per process, one element per resource type.
  logic [AROW_W-1:0] alloc_mem [PROCS];
  logic [NROW_W-1:0] need_mem  [PROCS];
  logic [AROW_W-1:0] alloc_row;
  logic [NROW_W-1:0] need_row;
  logic [AROW_W-1:0] mod_alloc;
  logic [NROW_W-1:0] mod_need;
  logic [AROW_W-1:0] alloc_wd;
  logic [NROW_W-1:0] need_wd;
  logic [RESOURCES-1:0] alloc_we;
  logic [RESOURCES-1:0] need_we;

  logic [WIDE_W-1:0] avail [RESOURCES];
  logic [WIDE_W-1:0] work  [RESOURCES];
  logic [AMT_W-1:0]  req   [RESOURCES];

  logic [AMT_W-1:0]  need_cur    [RESOURCES];
  logic [WIDE_W-1:0] alloc_cur   [RESOURCES];
  logic [AMT_W-1:0]  need_eff    [RESOURCES];
  logic [WIDE_W-1:0] alloc_eff   [RESOURCES];
  logic [SUM_W-1:0]  work_sum    [RESOURCES];
  logic [WIDE_W-1:0] work_add    [RESOURCES];
  logic [SUM_W-1:0]  grant_sum   [RESOURCES];
  logic [WIDE_W-1:0] grant_alloc [RESOURCES];
  logic [AMT_W-1:0]  grant_need  [RESOURCES];

  logic [RESOURCES-1:0] res_hit;
  logic [RESOURCES-1:0] fit_vec;
  logic [RESOURCES-1:0] exceed_vec;
  logic [RESOURCES-1:0] short_vec;

  logic [PROCS-1:0]  flags;
  logic [PROCS-1:0]  mask_ext;
  logic [MASK_W-1:0] mask_q;
  logic [PW-1:0]     ptr;
  logic [PW-1:0]     ptr_inc;
  logic [PW-1:0]     req_proc;
  logic [PW-1:0]     in_row;
  logic [PW-1:0]     rd_addr;
  logic [PW-1:0]     wr_addr;
  logic              granted;
  logic              use_mod;
  logic              proc_ok;
  logic              at_end;

  assign in_row  = PW'(process);
  assign proc_ok = int'(process) < PROCS;
  assign at_end  = (ptr == PW'(PROCS - 1));
  assign ptr_inc = at_end ? '0 : PW'(ptr + 1'b1);
  assign wr_addr = cmd.commit ? req_proc : in_row;
  // The requesting process is checked against its granted row, not the stored one.
  assign use_mod = granted && (ptr == req_proc);
  assign mask_ext = PROCS'(cmd.grant ? mask_q : finished_mask);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_INPUT: rd_addr = in_row;
      RD_ZERO:  rd_addr = '0;
      RD_NEXT:  rd_addr = ptr_inc;
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      res_hit[r]     = (int'(resource) == r);
      need_cur[r]    = need_row[r*AMT_W +: AMT_W];
      alloc_cur[r]   = alloc_row[r*WIDE_W +: WIDE_W];
      need_eff[r]    = use_mod ? mod_need[r*AMT_W +: AMT_W] : need_cur[r];
      alloc_eff[r]   = use_mod ? mod_alloc[r*WIDE_W +: WIDE_W] : alloc_cur[r];
      work_sum[r]    = {1'b0, work[r]} + {1'b0, alloc_eff[r]};
      work_add[r]    = work_sum[r][WIDE_W] ? WIDE_MAX : work_sum[r][WIDE_W-1:0];
      grant_sum[r]   = {1'b0, alloc_cur[r]} + SUM_W'(req[r]);
      grant_alloc[r] = grant_sum[r][WIDE_W] ? WIDE_MAX : grant_sum[r][WIDE_W-1:0];
      grant_need[r]  = need_cur[r] - req[r];
      fit_vec[r]     = WIDE_W'(need_eff[r]) <= work[r];
      exceed_vec[r]  = req[r] > need_cur[r];
      short_vec[r]   = WIDE_W'(req[r]) > avail[r];
      alloc_wd[r*WIDE_W +: WIDE_W] = cmd.commit ? mod_alloc[r*WIDE_W +: WIDE_W]
                                                : WIDE_W'(amount);
      need_wd[r*AMT_W +: AMT_W]    = cmd.commit ? mod_need[r*AMT_W +: AMT_W] : amount;
      alloc_we[r] = cmd.commit || (cmd.ld_alloc && proc_ok && res_hit[r]);
      need_we[r]  = cmd.commit || (cmd.ld_need && proc_ok && res_hit[r]);
    end
  end

  always_comb begin
    sts.proc_ok    = proc_ok;
    sts.exceed     = |exceed_vec;
    sts.over_avail = |short_vec;
    sts.can_take   = !flags[ptr] && (&fit_vec);
    sts.at_end     = at_end;
    sts.all_done   = &flags;
    sts.granted    = granted;
  end

  // Row memories: element-enable write port, one registered read port.
  always_ff @(posedge clk) begin
    for (int r = 0; r < RESOURCES; r++) begin
      if (alloc_we[r]) alloc_mem[wr_addr][r*WIDE_W +: WIDE_W] <= alloc_wd[r*WIDE_W +: WIDE_W];
      if (need_we[r]) need_mem[wr_addr][r*AMT_W +: AMT_W] <= need_wd[r*AMT_W +: AMT_W];
    end
    alloc_row <= alloc_mem[rd_addr];
    need_row  <= need_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < RESOURCES; r++) begin
        req[r]  <= '0;
        work[r] <= '0;
      end
      flags        <= '0;
      ptr          <= '0;
      granted      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      for (int r = 0; r < RESOURCES; r++) begin
        if (cmd.clr_req) begin
          req[r] <= '0;
        end else if (cmd.ld_req && res_hit[r]) begin
          req[r] <= amount;
        end
        if (cmd.init) begin
          work[r] <= avail[r] - (cmd.grant ? WIDE_W'(req[r]) : '0);
        end else if (cmd.take) begin
          work[r] <= work_add[r];
        end
      end
      if (cmd.init) begin
        flags   <= mask_ext;
        ptr     <= '0;
        granted <= cmd.grant;
      end else if (cmd.take) begin
        flags[ptr] <= 1'b1;
        ptr        <= '0;
      end else if (cmd.step) begin
        ptr <= ptr_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < RESOURCES; r++) begin
      if (cmd.ld_avail && res_hit[r]) begin
        avail[r] <= WIDE_W'(amount);
      end else if (cmd.commit) begin
        avail[r] <= avail[r] - WIDE_W'(req[r]);
      end
      if (cmd.grant) begin
        mod_alloc[r*WIDE_W +: WIDE_W] <= grant_alloc[r];
        mod_need[r*AMT_W +: AMT_W]    <= grant_need[r];
      end
    end
    if (cmd.cap) begin
      req_proc <= in_row;
      mask_q   <= finished_mask;
    end
    status     <= cmd.code;
    process_id <= (cmd.code == ST_SEQ) ? 3'(ptr) : 3'd0;
    last       <= cmd.last;
  end

endmodule

FILE: src/bnk_controller.sv
// Controller: decodes each request and sequences the grant check and the
// safety scan. Depends on bnk_pkg; drives bnk_datapath through cmd_t.
`timescale 1ns / 1ps

module bnk_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [2:0]    mode,
  input  logic          last_element,
  input  bnk_pkg::sts_t sts,
  output bnk_pkg::cmd_t cmd,
  output logic          busy
);
  import bnk_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_REQ  = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_ACK;
    cmd.rd_sel = RD_INPUT;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            MODE_ALLOC: begin
              cmd.ld_alloc = 1'b1;
              cmd.emit     = 1'b1;
              cmd.last     = 1'b1;
            end
            MODE_NEED: begin
              cmd.ld_need = 1'b1;
              cmd.emit    = 1'b1;
              cmd.last    = 1'b1;
            end
            MODE_AVAIL: begin
              cmd.ld_avail = 1'b1;
              cmd.emit     = 1'b1;
              cmd.last     = 1'b1;
            end
            MODE_REQ: begin
              cmd.ld_req = 1'b1;
              if (!last_element) begin
                cmd.emit = 1'b1;
                cmd.last = 1'b1;
              end else if (!sts.proc_ok) begin
                cmd.clr_req = 1'b1;
                cmd.emit    = 1'b1;
                cmd.code    = ST_EXCEED;
                cmd.last    = 1'b1;
              end else begin
                // The row of the requesting process is read during this cycle.
                cmd.cap    = 1'b1;
                state_next = S_REQ;
              end
            end
            MODE_CHECK: begin
              cmd.init   = 1'b1;
              cmd.rd_sel = RD_ZERO;
              state_next = S_SCAN;
            end
            default: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
            end
          endcase
        end
      end
      S_REQ: begin
        if (sts.exceed || sts.over_avail) begin
          cmd.clr_req = 1'b1;
          cmd.emit    = 1'b1;
          cmd.code    = sts.exceed ? ST_EXCEED : ST_WAIT;
          cmd.last    = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.grant  = 1'b1;
          cmd.init   = 1'b1;
          cmd.rd_sel = RD_ZERO;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.can_take) begin
          // Reclaim and restart the scan from the lowest process.
          cmd.take   = 1'b1;
          cmd.emit   = 1'b1;
          cmd.code   = ST_SEQ;
          cmd.rd_sel = RD_ZERO;
        end else if (sts.at_end || sts.all_done) begin
          // A granted request is written back only when the state proves safe.
          cmd.commit  = sts.all_done && sts.granted;
          cmd.clr_req = sts.granted;
          cmd.emit    = 1'b1;
          cmd.code    = sts.all_done ? ST_SAFE : ST_UNSAFE;
          cmd.last    = 1'b1;
          state_next  = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/bankers_safety_and_request_check.sv
// Top level of the banker's deadlock-avoidance engine.
// Joins bnk_controller and bnk_datapath; depends on bnk_pkg.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// Mode selects: load allocation, load need, load available, buffer one
// request element, or run a safety check with finished_mask. Results appear
// on status, process_id and last for exactly one cycle, flagged by
// result_valid; the receiver must take them, there is no back-pressure.
// Loads, plain request elements and undefined modes answer one ack in the
// cycle after acceptance and leave busy low, so one such request per cycle.
// A completed request first reads the process row and checks need and
// available; if they allow it, a safety check follows, else it answers
// exceed or wait. The check evaluates one process per cycle against the
// work vector, all resources in parallel, and restarts from process zero
// after every reclaim, giving one sequence entry per reclaimed process,
// then safe or unsafe with last set.
// A granted request is written back only if the check ends safe.
// Reset clears the controller, request buffer, work vector and flags; the
// tables and available vector hold no value until loaded.
`timescale 1ns / 1ps

module bankers_safety_and_request_check #(
  parameter int PROCS     = bnk_pkg::PROCS_DEF,
  parameter int RESOURCES = bnk_pkg::RESOURCES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] mode,
  input  logic [2:0] process,
  input  logic [1:0] resource,
  input  logic [7:0] amount,
  input  logic       last_element,
  input  logic [7:0] finished_mask,
  output logic       result_valid,
  output logic [2:0] status,
  output logic [2:0] process_id,
  output logic       last
);
  import bnk_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bnk_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .last_element (last_element),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  bnk_datapath #(
    .PROCS     (PROCS),
    .RESOURCES (RESOURCES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .process       (process),
    .resource      (resource),
    .amount        (amount),
    .finished_mask (finished_mask),
    .sts           (sts),
    .result_valid  (result_valid),
    .status        (status),
    .process_id    (process_id),
    .last          (last)
  );

endmodule

FILE: src/bnk_checker.sv
// Port-level checker for the banker's engine, bound to the top level.
// Depends on bnk_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bnk_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [2:0] mode,
  input logic       result_valid,
  input logic [2:0] status,
  input logic       last
);
  import bnk_pkg::*;

  // Loads and undefined-mode requests, which leave busy low, answer one ack right away.
  `ASSERT_NEXT(a_quick_ack, clk, rst, start && !busy && mode != MODE_REQ && mode != MODE_CHECK, result_valid && last && status == ST_ACK)

  // A sequence entry never closes a request.
  `ASSERT_IMPLY(a_seq_not_last, clk, rst, result_valid && status == ST_SEQ, !last)

  // Verdicts always close a request.
  `ASSERT_IMPLY(a_verdict_last, clk, rst, result_valid && (status == ST_SAFE || status == ST_UNSAFE || status == ST_WAIT || status == ST_EXCEED), last)

  // The final result shows once the engine is free again.
  `ASSERT_IMPLY(a_last_idle, clk, rst, result_valid && last, !busy)

  // Starting a long request emits nothing in its first busy cycle.
  `ASSERT_IMPLY(a_rise_quiet, clk, rst, $rose(busy), !result_valid)

endmodule

bind bankers_safety_and_request_check bnk_checker u_checker (.*);

FILE: dv/bankers_safety_and_request_check_test.sv
// Self-checking testbench for bankers_safety_and_request_check.
// Loads every table entry, walks a short stimulus table, then sends random
// traffic, checking each result against an in-file predictor or, for typed rows, the table's expected status.
// Depends on bnk_pkg and the top level of the block.
`timescale 1ns / 1ps

module bankers_safety_and_request_check_test;
  import bnk_pkg::*;

  localparam int NPROC = PROCS_DEF;
  localparam int NRES = RESOURCES_DEF;
  localparam int RANDOM_ITEMS = 410;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam logic [2:0] PUMP_PROC = 3'd7;
  localparam logic [7:0] PRELOAD_NEED = 8'd20;
  localparam logic [7:0] PRELOAD_AVAIL = 8'd100;

  typedef struct {
    logic [2:0] mode;
    logic [2:0] proc;
    logic [1:0] res;
    logic [7:0] amount;
    logic       last_el;
    logic [7:0] mask;
    bit         typed;
    status_t    exp;
  } item_t;

  typedef struct {
    status_t    code;
    logic [2:0] pid;
    logic       last;
  } outcome_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] mode;
  logic [2:0] proc_sel;
  logic [1:0] resource;
  logic [7:0] amount;
  logic       last_element;
  logic [7:0] finished_mask;
  logic       result_valid;
  logic [2:0] status;
  logic [2:0] process_id;
  logic       last;

  bankers_safety_and_request_check dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .process(proc_sel),
    .resource(resource),
    .amount(amount),
    .last_element(last_element),
    .finished_mask(finished_mask),
    .result_valid(result_valid),
    .status(status),
    .process_id(process_id),
    .last(last)
  );

  // Predicted state of the engine.
  logic [WIDE_W-1:0] alloc_tbl [NPROC][NRES];
  logic [AMT_W-1:0]  need_tbl  [NPROC][NRES];
  logic [WIDE_W-1:0] avail_vec [NRES];
  logic [AMT_W-1:0]  req_buf   [NRES];

  outcome_t step_results[$];
  outcome_t pending_results[$];
  item_t    directed_rows[$];
  int       error_count = 0;
  int       stall_cycles = 0;
  int       items_sent = 0;
  int       idle_pct = 25;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void note(status_t code, logic [2:0] pid, logic fin);
    outcome_t entry;
    entry = '{code, pid, fin};
    step_results.insert(step_results.size(), entry);
  endfunction

  // Scans for the lowest unfinished process whose need fits the work vector,
  // reclaims its allocation and restarts from process zero.
  function automatic bit run_safety(logic [7:0] mask);
    logic [WIDE_W-1:0] work [NRES];
    logic [SUM_W-1:0]  sum;
    logic [NPROC-1:0]  fin;
    bit found;
    bit fits;
    int p;
    int r;
    fin = mask[NPROC-1:0];
    for (r = 0; r < NRES; r++) work[r] = avail_vec[r];
    found = 1'b1;
    while (found) begin
      found = 1'b0;
      for (p = 0; p < NPROC && !found; p++) begin
        if (!fin[p]) begin
          fits = 1'b1;
          for (r = 0; r < NRES; r++)
            if (need_tbl[p][r] > work[r]) fits = 1'b0;
          if (fits) begin
            for (r = 0; r < NRES; r++) begin
              sum = work[r] + alloc_tbl[p][r];
              work[r] = (sum > WIDE_MAX) ? WIDE_MAX : sum[WIDE_W-1:0];
            end
            fin[p] = 1'b1;
            note(ST_SEQ, 3'(p), 1'b0);
            found = 1'b1;
          end
        end
      end
    end
    note((&fin) ? ST_SAFE : ST_UNSAFE, 3'd0, 1'b1);
    return &fin;
  endfunction

  function automatic void grant_request(logic [2:0] p, logic [7:0] mask);
    logic [WIDE_W-1:0] old_alloc [NRES];
    logic [AMT_W-1:0]  old_need  [NRES];
    logic [WIDE_W-1:0] old_avail [NRES];
    logic [SUM_W-1:0]  sum;
    int r;
    for (r = 0; r < NRES; r++)
      if (req_buf[r] > need_tbl[p][r]) begin
        note(ST_EXCEED, 3'd0, 1'b1);
        return;
      end
    for (r = 0; r < NRES; r++)
      if (req_buf[r] > avail_vec[r]) begin
        note(ST_WAIT, 3'd0, 1'b1);
        return;
      end
    for (r = 0; r < NRES; r++) begin
      old_alloc[r] = alloc_tbl[p][r];
      old_need[r] = need_tbl[p][r];
      old_avail[r] = avail_vec[r];
      sum = alloc_tbl[p][r] + req_buf[r];
      alloc_tbl[p][r] = (sum > WIDE_MAX) ? WIDE_MAX : sum[WIDE_W-1:0];
      need_tbl[p][r] = need_tbl[p][r] - req_buf[r];
      avail_vec[r] = avail_vec[r] - req_buf[r];
    end
    if (!run_safety(mask)) begin
      for (r = 0; r < NRES; r++) begin
        alloc_tbl[p][r] = old_alloc[r];
        need_tbl[p][r] = old_need[r];
        avail_vec[r] = old_avail[r];
      end
    end
  endfunction

  function automatic void bank_step(item_t it);
    int r;
    case (it.mode)
      MODE_ALLOC: begin
        alloc_tbl[it.proc][it.res] = WIDE_W'(it.amount);
        note(ST_ACK, 3'd0, 1'b1);
      end
      MODE_NEED: begin
        need_tbl[it.proc][it.res] = it.amount;
        note(ST_ACK, 3'd0, 1'b1);
      end
      MODE_AVAIL: begin
        avail_vec[it.res] = WIDE_W'(it.amount);
        note(ST_ACK, 3'd0, 1'b1);
      end
      MODE_REQ: begin
        req_buf[it.res] = it.amount;
        if (!it.last_el) begin
          note(ST_ACK, 3'd0, 1'b1);
        end else begin
          grant_request(it.proc, it.mask);
          for (r = 0; r < NRES; r++) req_buf[r] = '0;
        end
      end
      MODE_CHECK: begin
        void'(run_safety(it.mask));
      end
      default: begin
        note(ST_ACK, 3'd0, 1'b1);
      end
    endcase
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it.mode = 3'($urandom_range(0, 7));
    it.proc = 3'($urandom_range(0, 7));
    it.res = 2'($urandom_range(0, 3));
    it.amount = 8'($urandom_range(0, 255));
    it.last_el = 1'($urandom_range(0, 1));
    it.mask = 8'($urandom_range(0, 255));
    it.typed = 1'b0;
    it.exp = ST_ACK;
    return it;
  endfunction

  function automatic logic [7:0] pick_mask();
    case ($urandom_range(0, 3))
      0, 1: return 8'h00;
      2: return 8'($urandom_range(0, 255));
      default: return ~(8'h01 << $urandom_range(0, 7));
    endcase
  endfunction

  task automatic add_row(logic [2:0] md, logic [2:0] p, logic [1:0] r, logic [7:0] amt,
                         logic lst, logic [7:0] msk, bit typed, status_t exp);
    item_t row;
    row = '{md, p, r, amt, lst, msk, typed, exp};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Presents one request, waits until it is taken and queues what it should cause.
  // The sender stays idle for each cycle with a chance of idle_pct percent.
  task automatic send_item(item_t it);
    outcome_t typed_res;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    mode <= it.mode;
    proc_sel <= it.proc;
    resource <= it.res;
    amount <= it.amount;
    last_element <= it.last_el;
    finished_mask <= it.mask;
    do @(posedge clk); while (busy);
    items_sent++;
    step_results.delete();
    bank_step(it);
    if (it.typed) begin
      typed_res = '{it.exp, 3'd0, 1'b1};
      pending_results.insert(pending_results.size(), typed_res);
    end else begin
      foreach (step_results[i]) pending_results.insert(pending_results.size(), step_results[i]);
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if (result_valid) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d process_id=%0d last=%0b",
                   $time, status, process_id, last);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (status !== want.code || process_id !== want.pid || last !== want.last) begin
            $display(
              "%0t: mismatch expected status=%0d pid=%0d last=%0b, got status=%0d pid=%0d last=%0b",
              $time, want.code, want.pid, want.last, status, process_id, last);
            error_count++;
          end
        end
      end
      if (result_valid || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    item_t it;
    int p;
    int r;
    int k;
    int cnt;
    int first_res;
    int rand_base;
    int done;
    int pick;
    logic [7:0] cap;

    rst <= 1'b1;
    start <= 1'b0;
    mode <= MODE_ALLOC;
    proc_sel <= '0;
    resource <= '0;
    amount <= '0;
    last_element <= 1'b0;
    finished_mask <= '0;
    for (r = 0; r < NRES; r++) req_buf[r] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Every table entry is written before anything reads it.
    it = noise_item();
    for (p = 0; p < NPROC; p++)
      for (r = 0; r < NRES; r++) begin
        it.mode = MODE_ALLOC; it.proc = 3'(p); it.res = 2'(r); it.amount = 8'd0;
        send_item(it);
        it.mode = MODE_NEED; it.amount = PRELOAD_NEED;
        send_item(it);
      end
    for (r = 0; r < NRES; r++) begin
      it.mode = MODE_AVAIL; it.res = 2'(r); it.amount = PRELOAD_AVAIL;
      send_item(it);
    end

    //      mode        proc  res   amount lastel mask   typed expected
    add_row(MODE_RSVD5, 3'd0, 2'd0, 8'd0,   1'b0, 8'h00, 1'b1, ST_ACK);
    add_row(MODE_RSVD6, 3'd5, 2'd2, 8'd170, 1'b1, 8'h55, 1'b1, ST_ACK);
    add_row(MODE_RSVD7, 3'd7, 2'd3, 8'd255, 1'b1, 8'hFF, 1'b1, ST_ACK);
    add_row(MODE_CHECK, 3'd0, 2'd0, 8'd0,   1'b0, 8'hFF, 1'b1, ST_SAFE);
    add_row(MODE_CHECK, 3'd0, 2'd0, 8'd0,   1'b0, 8'h00, 1'b0, ST_ACK);
    add_row(MODE_REQ,   3'd2, 2'd0, 8'd255, 1'b0, 8'h00, 1'b1, ST_ACK);
    add_row(MODE_REQ,   3'd2, 2'd1, 8'd0,   1'b1, 8'h00, 1'b1, ST_EXCEED);
    add_row(MODE_REQ,   3'd3, 2'd0, 8'd20,  1'b1, 8'h00, 1'b0, ST_ACK);
    add_row(MODE_AVAIL, 3'd0, 2'd2, 8'd0,   1'b0, 8'h00, 1'b1, ST_ACK);
    add_row(MODE_REQ,   3'd4, 2'd2, 8'd5,   1'b1, 8'h00, 1'b1, ST_WAIT);
    // A zero request with nothing able to finish is granted, found unsafe
    // and rolled back.
    add_row(MODE_REQ,   3'd1, 2'd0, 8'd0,   1'b1, 8'h00, 1'b0, ST_ACK);
    add_row(MODE_NEED,  3'd0, 2'd3, 8'd255, 1'b0, 8'h00, 1'b1, ST_ACK);
    add_row(MODE_AVAIL, 3'd0, 2'd2, 8'd255, 1'b0, 8'h00, 1'b1, ST_ACK);
    add_row(MODE_AVAIL, 3'd0, 2'd3, 8'd255, 1'b0, 8'h00, 1'b1, ST_ACK);
    add_row(MODE_CHECK, 3'd0, 2'd0, 8'd0,   1'b0, 8'h00, 1'b0, ST_ACK);
    add_row(MODE_CHECK, 3'd0, 2'd0, 8'd0,   1'b0, 8'hAA, 1'b0, ST_ACK);
    add_row(MODE_ALLOC, 3'd7, 2'd3, 8'd255, 1'b0, 8'h00, 1'b1, ST_ACK);
    add_row(MODE_CHECK, 3'd0, 2'd0, 8'd0,   1'b0, 8'h01, 1'b0, ST_ACK);
    add_row(MODE_CHECK, 3'd0, 2'd0, 8'd0,   1'b0, 8'h80, 1'b0, ST_ACK);
    add_row(MODE_REQ,   3'd5, 2'd0, 8'd3,   1'b0, 8'h00, 1'b1, ST_ACK);
    add_row(MODE_REQ,   3'd5, 2'd1, 8'd4,   1'b0, 8'h00, 1'b1, ST_ACK);
    add_row(MODE_REQ,   3'd5, 2'd3, 8'd5,   1'b1, 8'h0F, 1'b0, ST_ACK);
    add_row(MODE_NEED,  3'd6, 2'd1, 8'd0,   1'b0, 8'h00, 1'b1, ST_ACK);
    add_row(MODE_ALLOC, 3'd0, 2'd0, 8'd0,   1'b0, 8'h00, 1'b1, ST_ACK);
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    rand_base = items_sent;
    while (items_sent - rand_base < RANDOM_ITEMS) begin
      done = items_sent - rand_base;
      idle_pct = (done < RANDOM_ITEMS / 3) ? 25 : (done < 2 * RANDOM_ITEMS / 3) ? 71 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // Full-size grant on one process with the others marked finished:
        // always safe, so its allocation climbs toward saturation.
        for (r = 0; r < NRES; r++) begin
          it = noise_item(); it.mode = MODE_NEED; it.proc = PUMP_PROC;
          it.res = 2'(r); it.amount = 8'hFF;
          send_item(it);
        end
        for (r = 0; r < NRES; r++) begin
          it = noise_item(); it.mode = MODE_AVAIL; it.res = 2'(r); it.amount = 8'hFF;
          send_item(it);
        end
        for (r = 0; r < NRES; r++) begin
          it = noise_item(); it.mode = MODE_REQ; it.proc = PUMP_PROC; it.res = 2'(r);
          it.amount = 8'hFF; it.last_el = (r == NRES - 1);
          it.mask = ~(8'h01 << PUMP_PROC);
          send_item(it);
        end
      end else if (pick < 40) begin
        p = $urandom_range(0, NPROC - 1);
        cnt = $urandom_range(1, NRES);
        first_res = $urandom_range(0, NRES - 1);
        for (k = 0; k < cnt; k++) begin
          r = (first_res + k) % NRES;
          cap = (need_tbl[p][r] < avail_vec[r]) ? need_tbl[p][r] : avail_vec[r][7:0];
          it = noise_item(); it.mode = MODE_REQ; it.proc = 3'(p); it.res = 2'(r);
          it.amount = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, cap))
                                                    : 8'($urandom_range(0, 255));
          it.last_el = (k == cnt - 1);
          if (it.last_el) it.mask = pick_mask();
          send_item(it);
        end
      end else if (pick < 52) begin
        it = noise_item(); it.mode = MODE_CHECK; it.mask = pick_mask();
        send_item(it);
      end else if (pick < 92) begin
        it = noise_item();
        case ($urandom_range(0, 2))
          0: begin
            it.mode = MODE_ALLOC;
            it.amount = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 40))
                                                   : 8'($urandom_range(0, 255));
            if (it.proc == PUMP_PROC && $urandom_range(0, 7) != 0) it.proc = PUMP_PROC - 3'd1;
          end
          1: begin
            it.mode = MODE_NEED;
            it.amount = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 30))
                                                   : 8'($urandom_range(0, 255));
          end
          default: begin
            it.mode = MODE_AVAIL;
            it.amount = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(60, 255))
                                                   : 8'($urandom_range(0, 255));
          end
        endcase
        send_item(it);
      end else begin
        it = noise_item();
        it.mode = 3'($urandom_range(MODE_RSVD5, MODE_RSVD7));
        send_item(it);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
